### rtl/mffp_pkg.sv
`timescale 1ns / 1ps
package mffp_pkg;

  localparam int MOTOR_COUNT     = 30;
  localparam int BYTES_PER_MOTOR = 5;
  localparam int FRAME_LAST      = BYTES_PER_MOTOR * MOTOR_COUNT + 1;
  localparam int POS_W           = $clog2(FRAME_LAST + 1);
  localparam int MI_W            = (MOTOR_COUNT > 1) ? $clog2(MOTOR_COUNT) : 1;
  localparam int ADDR_W          = $clog2(2 * MOTOR_COUNT);
  localparam int ENTRY_W         = 8 * BYTES_PER_MOTOR;
  localparam int SHIFT_W         = 8 * (BYTES_PER_MOTOR - 1);
  localparam int BIM_W           = 3;
  localparam int CFG_INDEX_W     = 3;

  localparam int POS_BITS = 16;
  localparam int VT_BITS  = 12;
  localparam int PROD_W   = 48;

  localparam logic [7:0]  HEADER_RESET  = 8'hA5;
  localparam logic [31:0] POS_MIN_RESET = 32'hFFF3_8000;
  localparam logic [31:0] POS_MAX_RESET = 32'h000C_8000;
  localparam logic [31:0] VEL_MIN_RESET = 32'hFFE2_0000;
  localparam logic [31:0] VEL_MAX_RESET = 32'h001E_0000;
  localparam logic [31:0] TOR_MIN_RESET = 32'hFFF6_0000;
  localparam logic [31:0] TOR_MAX_RESET = 32'h000A_0000;

  localparam logic [1:0] STATUS_GOOD       = 2'd0;
  localparam logic [1:0] STATUS_BAD_HEADER = 2'd1;
  localparam logic [1:0] STATUS_BAD_CHECK  = 2'd2;

  localparam logic [CFG_INDEX_W-1:0] REG_HEADER  = 3'd0;
  localparam logic [CFG_INDEX_W-1:0] REG_POS_MIN = 3'd1;
  localparam logic [CFG_INDEX_W-1:0] REG_POS_MAX = 3'd2;
  localparam logic [CFG_INDEX_W-1:0] REG_VEL_MIN = 3'd3;
  localparam logic [CFG_INDEX_W-1:0] REG_VEL_MAX = 3'd4;
  localparam logic [CFG_INDEX_W-1:0] REG_TOR_MIN = 3'd5;
  localparam logic [CFG_INDEX_W-1:0] REG_TOR_MAX = 3'd6;

  typedef struct packed {
    logic [1:0] status;
    logic       bank;
  } job_t;

  typedef struct packed {
    logic               en;
    logic [ADDR_W-1:0]  addr;
    logic [ENTRY_W-1:0] data;
  } mem_wr_t;

  typedef struct packed {
    logic en;
    logic bank;
  } rel_t;

  typedef struct packed {
    logic signed [31:0] pos_min;
    logic signed [31:0] pos_max;
    logic signed [31:0] vel_min;
    logic signed [31:0] vel_max;
    logic signed [31:0] tor_min;
    logic signed [31:0] tor_max;
  } range_cfg_t;

endpackage

### rtl/mffp_if.sv
`timescale 1ns / 1ps
interface mffp_byte_if;
  logic       valid;
  logic       ready;
  logic [7:0] rx_byte;
  modport source (output valid, output rx_byte, input ready);
  modport sink (input valid, input rx_byte, output ready);
endinterface

interface mffp_result_if;
  logic               valid;
  logic               ready;
  logic [5:0]         motor_number;
  logic [15:0]        pos_code;
  logic [11:0]        vel_code;
  logic [11:0]        tor_code;
  logic signed [31:0] pos_value;
  logic signed [31:0] vel_value;
  logic signed [31:0] tor_value;
  logic [1:0]         frame_status;
  logic               last_of_frame;
  modport source (output valid, output motor_number, output pos_code, output vel_code,
                  output tor_code, output pos_value, output vel_value, output tor_value,
                  output frame_status, output last_of_frame, input ready);
  modport sink (input valid, input motor_number, input pos_code, input vel_code,
                input tor_code, input pos_value, input vel_value, input tor_value,
                input frame_status, input last_of_frame, output ready);
endinterface

interface mffp_cfg_if;
  logic        valid;
  logic        ready;
  logic [2:0]  index;
  logic [31:0] data;
  modport source (output valid, output index, output data, input ready);
  modport sink (input valid, input index, input data, output ready);
endinterface

### rtl/mffp_front.sv
`timescale 1ns / 1ps
module mffp_front import mffp_pkg::*; (
  input  logic        clk,
  input  logic        rst,
  mffp_byte_if.sink   rx,
  input  logic [7:0]  expected_header,
  input  rel_t        rel,
  output logic        push_valid,
  input  logic        push_ready,
  output job_t        push_job,
  output mem_wr_t     wr
);

  logic [POS_W-1:0]   byte_pos;
  logic [7:0]         running_xor;
  logic [7:0]         header_seen;
  logic               bank;
  logic [1:0]         bank_busy;
  logic [1:0]         bank_busy_next;
  logic [MI_W-1:0]    motor_slot;
  logic [BIM_W-1:0]   byte_in_motor;
  logic [SHIFT_W-1:0] shift;
  logic               accept;
  logic               is_check;
  logic [1:0]         status;

  assign rx.ready = !bank_busy[bank] && push_ready;
  assign accept   = rx.valid && rx.ready;
  assign is_check = (byte_pos == POS_W'(FRAME_LAST));

  always_comb begin
    if (header_seen != expected_header) begin
      status = STATUS_BAD_HEADER;
    end else if (running_xor != rx.rx_byte) begin
      status = STATUS_BAD_CHECK;
    end else begin
      status = STATUS_GOOD;
    end
  end

  always_comb begin
    bank_busy_next = bank_busy;
    if (rel.en) begin
      bank_busy_next[rel.bank] = 1'b0;
    end
    if (accept && is_check) begin
      bank_busy_next[bank] = 1'b1;
    end
  end

  assign push_valid      = accept && is_check;
  assign push_job.status = status;
  assign push_job.bank   = bank;

  assign wr.en   = accept && (byte_pos != '0) && !is_check
                   && (byte_in_motor == BIM_W'(BYTES_PER_MOTOR - 1));
  assign wr.addr = bank ? ADDR_W'(MOTOR_COUNT) + ADDR_W'(motor_slot) : ADDR_W'(motor_slot);
  assign wr.data = {shift, rx.rx_byte};

  always_ff @(posedge clk) begin
    if (rst) begin
      byte_pos      <= '0;
      running_xor   <= '0;
      header_seen   <= '0;
      bank          <= 1'b0;
      bank_busy     <= '0;
      motor_slot    <= '0;
      byte_in_motor <= '0;
    end else begin
      bank_busy <= bank_busy_next;
      if (accept) begin
        if (byte_pos == '0) begin
          header_seen   <= rx.rx_byte;
          running_xor   <= running_xor ^ rx.rx_byte;
          byte_pos      <= byte_pos + 1'b1;
          motor_slot    <= '0;
          byte_in_motor <= '0;
        end else if (!is_check) begin
          running_xor <= running_xor ^ rx.rx_byte;
          byte_pos    <= byte_pos + 1'b1;
          if (byte_in_motor == BIM_W'(BYTES_PER_MOTOR - 1)) begin
            byte_in_motor <= '0;
            motor_slot    <= motor_slot + 1'b1;
          end else begin
            byte_in_motor <= byte_in_motor + 1'b1;
          end
        end else begin
          bank        <= !bank;
          byte_pos    <= '0;
          running_xor <= '0;
        end
      end
    end
  end

  always_ff @(posedge clk) begin
    if (accept && !is_check && (byte_pos != '0)) begin
      shift <= {shift[SHIFT_W-9:0], rx.rx_byte};
    end
  end

endmodule

### rtl/mffp_queue.sv
`timescale 1ns / 1ps
module mffp_queue import mffp_pkg::*; (
  input  logic clk,
  input  logic rst,
  input  logic push_valid,
  output logic push_ready,
  input  job_t push_job,
  output logic pop_valid,
  input  logic pop_ready,
  output job_t pop_job
);

  job_t       slots [2];
  logic       wr_ptr;
  logic       rd_ptr;
  logic [1:0] count;
  logic       do_push;
  logic       do_pop;

  assign push_ready = (count != 2'd2);
  assign pop_valid  = (count != 2'd0);
  assign pop_job    = slots[rd_ptr];
  assign do_push    = push_valid && push_ready;
  assign do_pop     = pop_valid && pop_ready;

  always_ff @(posedge clk) begin
    if (rst) begin
      wr_ptr <= 1'b0;
      rd_ptr <= 1'b0;
      count  <= '0;
    end else begin
      if (do_push) begin
        wr_ptr <= !wr_ptr;
      end
      if (do_pop) begin
        rd_ptr <= !rd_ptr;
      end
      if (do_push && !do_pop) begin
        count <= count + 1'b1;
      end else if (do_pop && !do_push) begin
        count <= count - 1'b1;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (do_push) begin
      slots[wr_ptr] <= push_job;
    end
  end

endmodule

### rtl/mffp_scale.sv
`timescale 1ns / 1ps
module mffp_scale import mffp_pkg::*; (
  input  logic               clk,
  input  logic               rst,
  input  logic               start,
  input  logic               wide,
  input  logic [15:0]        code,
  input  logic signed [31:0] lo,
  input  logic signed [31:0] hi,
  output logic               busy,
  output logic signed [31:0] value
);

  typedef enum logic [1:0] {S_IDLE, S_MUL, S_DIV} state_t;

  state_t              state;
  logic [15:0]         code_r;
  logic [31:0]         span;
  logic signed [31:0]  lo_r;
  logic                keep_lo;
  logic                wide_r;
  logic [PROD_W-1:0]   x;
  logic [31:0]         q;
  logic signed [32:0]  diff;
  logic [PROD_W-1:0]   prod;
  logic [PROD_W-1:0]   mask;
  logic [PROD_W-1:0]   hi_part;
  logic [PROD_W-1:0]   lo_part;
  logic [31:0]         q_final;

  assign diff    = 33'(hi) - 33'(lo);
  assign prod    = code_r * span;
  assign mask    = wide_r ? PROD_W'({POS_BITS{1'b1}}) : PROD_W'({VT_BITS{1'b1}});
  assign hi_part = wide_r ? (x >> POS_BITS) : (x >> VT_BITS);
  assign lo_part = x & mask;
  assign q_final = (lo_part == mask) ? q + 1'b1 : q;

  // Division by 2^n-1: fold the high digit back into the low one until one digit is left.
  always_ff @(posedge clk) begin
    if (rst) begin
      state <= S_IDLE;
      busy  <= 1'b0;
    end else begin
      unique case (state)
        S_IDLE: begin
          if (start) begin
            code_r  <= code;
            span    <= diff[31:0];
            lo_r    <= lo;
            keep_lo <= !(hi > lo);
            wide_r  <= wide;
            busy    <= 1'b1;
            state   <= S_MUL;
          end
        end
        S_MUL: begin
          x     <= prod;
          q     <= '0;
          state <= S_DIV;
        end
        S_DIV: begin
          if (hi_part != '0) begin
            q <= q + hi_part[31:0];
            x <= hi_part + lo_part;
          end else begin
            value <= keep_lo ? lo_r : lo_r + $signed(q_final);
            busy  <= 1'b0;
            state <= S_IDLE;
          end
        end
        default: state <= S_IDLE;
      endcase
    end
  end

endmodule

### rtl/mffp_back.sv
`timescale 1ns / 1ps
module mffp_back import mffp_pkg::*; (
  input  logic          clk,
  input  logic          rst,
  input  mem_wr_t       wr,
  input  logic          pop_valid,
  output logic          pop_ready,
  input  job_t          pop_job,
  input  range_cfg_t    rng,
  output rel_t          rel,
  mffp_result_if.source res
);

  typedef enum logic [1:0] {B_IDLE, B_READ, B_DECODE, B_CALC} state_t;

  state_t             state;
  job_t               job;
  logic [MI_W-1:0]    motor;
  logic [ENTRY_W-1:0] mem [2 * MOTOR_COUNT];
  logic [ENTRY_W-1:0] rd_data;
  logic [ADDR_W-1:0]  rd_addr;
  logic               rd_en;
  logic               start;
  logic               err;
  logic               last;
  logic               can_load;
  logic [2:0]         busy;
  logic signed [31:0] pos_v;
  logic signed [31:0] vel_v;
  logic signed [31:0] tor_v;
  logic [15:0]        pos_c;
  logic [11:0]        vel_c;
  logic [11:0]        tor_c;

  logic               valid_r;
  logic [5:0]         motor_number_r;
  logic [15:0]        pos_code_r;
  logic [11:0]        vel_code_r;
  logic [11:0]        tor_code_r;
  logic signed [31:0] pos_value_r;
  logic signed [31:0] vel_value_r;
  logic signed [31:0] tor_value_r;
  logic [1:0]         frame_status_r;
  logic               last_r;

  assign pop_ready = (state == B_IDLE);
  assign rd_en     = (state == B_READ);
  assign rd_addr   = job.bank ? ADDR_W'(MOTOR_COUNT) + ADDR_W'(motor) : ADDR_W'(motor);
  assign start     = (state == B_DECODE);
  assign err       = (job.status != STATUS_GOOD);
  assign last      = err || (motor == MI_W'(MOTOR_COUNT - 1));
  assign can_load  = (state == B_CALC) && (busy == '0) && (!valid_r || res.ready);
  assign rel.en    = can_load && last;
  assign rel.bank  = job.bank;

  always_ff @(posedge clk) begin
    if (wr.en) begin
      mem[wr.addr] <= wr.data;
    end
  end

  always_ff @(posedge clk) begin
    if (rd_en) begin
      rd_data <= mem[rd_addr];
    end
  end

  mffp_scale u_pos (
    .clk(clk), .rst(rst), .start(start), .wide(1'b1), .code(rd_data[39:24]),
    .lo(rng.pos_min), .hi(rng.pos_max), .busy(busy[0]), .value(pos_v)
  );

  mffp_scale u_vel (
    .clk(clk), .rst(rst), .start(start), .wide(1'b0), .code(16'(rd_data[23:12])),
    .lo(rng.vel_min), .hi(rng.vel_max), .busy(busy[1]), .value(vel_v)
  );

  mffp_scale u_tor (
    .clk(clk), .rst(rst), .start(start), .wide(1'b0), .code(16'(rd_data[11:0])),
    .lo(rng.tor_min), .hi(rng.tor_max), .busy(busy[2]), .value(tor_v)
  );

  always_ff @(posedge clk) begin
    if (rst) begin
      state   <= B_IDLE;
      valid_r <= 1'b0;
    end else begin
      if (can_load) begin
        valid_r <= 1'b1;
      end else if (res.ready) begin
        valid_r <= 1'b0;
      end
      unique case (state)
        B_IDLE: begin
          if (pop_valid) begin
            job   <= pop_job;
            motor <= '0;
            state <= (pop_job.status != STATUS_GOOD) ? B_CALC : B_READ;
          end
        end
        B_READ: begin
          state <= B_DECODE;
        end
        B_DECODE: begin
          pos_c <= rd_data[39:24];
          vel_c <= rd_data[23:12];
          tor_c <= rd_data[11:0];
          state <= B_CALC;
        end
        B_CALC: begin
          if (can_load) begin
            motor_number_r <= err ? 6'd0 : 6'(motor);
            pos_code_r     <= err ? 16'd0 : pos_c;
            vel_code_r     <= err ? 12'd0 : vel_c;
            tor_code_r     <= err ? 12'd0 : tor_c;
            pos_value_r    <= err ? 32'sd0 : pos_v;
            vel_value_r    <= err ? 32'sd0 : vel_v;
            tor_value_r    <= err ? 32'sd0 : tor_v;
            frame_status_r <= job.status;
            last_r         <= last;
            if (last) begin
              state <= B_IDLE;
            end else begin
              motor <= motor + 1'b1;
              state <= B_READ;
            end
          end
        end
        default: state <= B_IDLE;
      endcase
    end
  end

  assign res.valid         = valid_r;
  assign res.motor_number  = motor_number_r;
  assign res.pos_code      = pos_code_r;
  assign res.vel_code      = vel_code_r;
  assign res.tor_code      = tor_code_r;
  assign res.pos_value     = pos_value_r;
  assign res.vel_value     = vel_value_r;
  assign res.tor_value     = tor_value_r;
  assign res.frame_status  = frame_status_r;
  assign res.last_of_frame = last_r;

endmodule

### rtl/motor_feedback_frame_parser_core.sv
`timescale 1ns / 1ps
// Motor feedback frame parser. The rx channel takes one byte a word from a frame-aligned
// stream: a header, five packed bytes per motor and an XOR check byte. The res channel
// gives one word per motor for a good frame, or a single error word for a bad one, with
// last_of_frame set on the final word. The cfg channel writes the expected header and the
// six Q16.16 range registers and is always ready; write it only while the block is idle.
// Bytes are taken at one per cycle while rx.ready is high. The motor buffer has two banks,
// so a new frame fills one bank while the results of the previous frame are worked off
// from the other. Each motor result waits for the slowest of the three scaling units,
// which do one multiply and then fold the product by 2^n-1 one digit per cycle until one
// digit is left. An error word skips the buffer read and the scaling units, and a whole
// frame drains one motor at a time. If both banks still wait on the back end, rx.ready
// drops until a bank is released. When the receiver stalls, the result word holds in the
// output register and the next motor is computed behind it. Synchronous reset clears the
// frame counters and the job queue and restores the register defaults; the motor buffer
// is not cleared, since every entry is written within a frame before it is read.
module motor_feedback_frame_parser_core import mffp_pkg::*; (
  input  logic          clk,
  input  logic          rst,
  mffp_byte_if.sink     rx,
  mffp_result_if.source res,
  mffp_cfg_if.sink      cfg
);

  logic [7:0] expected_header;
  range_cfg_t rng;
  rel_t       rel;
  mem_wr_t    wr;
  logic       q_push_valid;
  logic       q_push_ready;
  job_t       q_push_job;
  logic       q_pop_valid;
  logic       q_pop_ready;
  job_t       q_pop_job;

  assign cfg.ready = 1'b1;

  always_ff @(posedge clk) begin
    if (rst) begin
      expected_header <= HEADER_RESET;
      rng.pos_min     <= POS_MIN_RESET;
      rng.pos_max     <= POS_MAX_RESET;
      rng.vel_min     <= VEL_MIN_RESET;
      rng.vel_max     <= VEL_MAX_RESET;
      rng.tor_min     <= TOR_MIN_RESET;
      rng.tor_max     <= TOR_MAX_RESET;
    end else if (cfg.valid && cfg.ready) begin
      unique case (cfg.index)
        REG_HEADER:  expected_header <= cfg.data[7:0];
        REG_POS_MIN: rng.pos_min     <= cfg.data;
        REG_POS_MAX: rng.pos_max     <= cfg.data;
        REG_VEL_MIN: rng.vel_min     <= cfg.data;
        REG_VEL_MAX: rng.vel_max     <= cfg.data;
        REG_TOR_MIN: rng.tor_min     <= cfg.data;
        REG_TOR_MAX: rng.tor_max     <= cfg.data;
        default: ;
      endcase
    end
  end

  mffp_front u_front (
    .clk(clk), .rst(rst), .rx(rx), .expected_header(expected_header), .rel(rel),
    .push_valid(q_push_valid), .push_ready(q_push_ready), .push_job(q_push_job), .wr(wr)
  );

  mffp_queue u_queue (
    .clk(clk), .rst(rst),
    .push_valid(q_push_valid), .push_ready(q_push_ready), .push_job(q_push_job),
    .pop_valid(q_pop_valid), .pop_ready(q_pop_ready), .pop_job(q_pop_job)
  );

  mffp_back u_back (
    .clk(clk), .rst(rst), .wr(wr),
    .pop_valid(q_pop_valid), .pop_ready(q_pop_ready), .pop_job(q_pop_job),
    .rng(rng), .rel(rel), .res(res)
  );

  a_err_is_last: assert property (@(posedge clk) disable iff (rst)
    res.valid && (res.frame_status != STATUS_GOOD) |-> res.last_of_frame)
    else $error("error word without last_of_frame");

  a_err_zero: assert property (@(posedge clk) disable iff (rst)
    res.valid && (res.frame_status != STATUS_GOOD) |->
      (res.motor_number == 6'd0) && (res.pos_code == 16'd0) && (res.pos_value == 32'sd0))
    else $error("error word carries motor data");

  a_last_motor: assert property (@(posedge clk) disable iff (rst)
    res.valid && (res.frame_status == STATUS_GOOD) && res.last_of_frame |->
      (res.motor_number == 6'(MOTOR_COUNT - 1)))
    else $error("last_of_frame on wrong motor");

  a_queue_room: assert property (@(posedge clk) disable iff (rst)
    q_push_valid |-> q_push_ready)
    else $error("job pushed into full queue");

endmodule
